@@ sv/dmsp_pkg.sv @@
// Shared types and constants for the dual motor speed PID unit.
package dmsp_pkg;

   localparam int NUM_MOTORS = 2;
   localparam int FRAC_BITS  = 8;
   localparam int MOTOR_W    = 1;
   localparam int SPEED_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int DUTY_W     = 10;
   localparam int ERR_W      = SPEED_W + 1;
   localparam int INTEG_W    = 32;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int PE_W       = GAIN_W + 1 + ERR_W;
   localparam int PI_W       = GAIN_W + INTEG_W;
   localparam int PD_W       = GAIN_W + 1 + DIFF_W;
   localparam int SUM_W      = PI_W + 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [DUTY_W-1:0] DUTY_RESET = DUTY_W'(60);

   typedef enum logic [1:0] {
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_DUTY_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [DUTY_W-1:0] duty_limit;
   } pid_cfg_type;

endpackage

@@ sv/dmsp_ifs.sv @@
// Valid/ready channel interfaces for speed requests and duty responses.
interface dmsp_req_if
   import dmsp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MOTOR_W-1:0] motor_select;
   logic [SPEED_W-1:0] speed_setpoint;
   logic [SPEED_W-1:0] measured_speed;

   modport source (output valid, output motor_select, output speed_setpoint,
                   output measured_speed, input ready);
   modport sink   (input valid, input motor_select, input speed_setpoint,
                   input measured_speed, output ready);
endinterface

interface dmsp_rsp_if
   import dmsp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MOTOR_W-1:0] motor_out;
   logic [DUTY_W-1:0]  duty;

   modport source (output valid, output motor_out, output duty, input ready);
   modport sink   (input valid, input motor_out, input duty, output ready);
endinterface

@@ sv/dmsp_csr.sv @@
// APB register file holding the PID gains and the duty limit.
module dmsp_csr
   import dmsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output pid_cfg_type           cfg
);

   pid_cfg_type   cfg_ff;
   pid_cfg_type   cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_GAIN_P:     cfg_in.gain_p     = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i     = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d     = csr_pwdata[GAIN_W-1:0];
            REG_DUTY_LIMIT: cfg_in.duty_limit = csr_pwdata[DUTY_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GAIN_P:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_p);
         REG_GAIN_I:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_i);
         REG_GAIN_D:     csr_prdata = CSR_DATA_W'(cfg_ff.gain_d);
         REG_DUTY_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.duty_limit);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= '0;
         cfg_ff.gain_i     <= '0;
         cfg_ff.gain_d     <= '0;
         cfg_ff.duty_limit <= DUTY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/dual_motor_speed_pid_unit.sv @@
// Positional PID speed regulator for two motors, one update per unstalled cycle.
//
// Each request names a motor and gives target and measured speed; the unit
// returns the motor number and a duty in 0..duty_limit from
// (kp*e + ki*integral + kd*(e - last_e)) >> 8, gains unsigned Q8.8, with a
// saturating 32-bit integral and previous error kept separately per motor.
// One request is taken every cycle unless the response side stalls, any mix
// of motors; a response goes from the input register through the error and
// integral update and the three parallel multipliers to sum and clamp into
// the output register. The per-motor integral and error are written back as
// a request leaves the input register, which is what lets back-to-back
// requests to the same motor go at full rate. Gains and duty_limit sit at byte
// addresses 0, 4, 8 and 12; write them only while no request is in flight.
module dual_motor_speed_pid_unit
   import dmsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dmsp_req_if.sink              req_bus,
   dmsp_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   pid_cfg_type cfg;

   dmsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stage valids and handshake
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   logic rdy0, rdy1, rdy2, rdy3;

   // Stage 0: input register
   logic [MOTOR_W-1:0] m0_ff;
   logic [SPEED_W-1:0] tgt0_ff, meas0_ff;

   // Stage 1: error terms
   logic [MOTOR_W-1:0]        m1_ff;
   logic signed [ERR_W-1:0]   e1_ff, e1_in;
   logic signed [INTEG_W-1:0] i1_ff, i1_in;
   logic signed [DIFF_W-1:0]  d1_ff, d1_in;

   // Stage 2: products
   logic [MOTOR_W-1:0]     m2_ff;
   logic signed [PE_W-1:0] pe2_ff, pe2_in;
   logic signed [PI_W-1:0] pi2_ff, pi2_in;
   logic signed [PD_W-1:0] pd2_ff, pd2_in;

   // Stage 3: output register
   logic [MOTOR_W-1:0] m3_ff;
   logic [DUTY_W-1:0]  duty3_ff, duty3_in;

   // Per-motor state
   logic signed [INTEG_W-1:0] integral_ff [NUM_MOTORS];
   logic signed [ERR_W-1:0]   last_err_ff [NUM_MOTORS];

   logic                    in_range;
   logic                    upd_state;
   logic signed [INTEG_W:0] integ_wide;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        shifted;
   logic signed [GAIN_W:0]  gp_s, gi_s, gd_s;

   assign rdy3 = !v3_ff || rsp_bus.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign req_bus.ready     = rdy0;
   assign rsp_bus.valid     = v3_ff;
   assign rsp_bus.motor_out = m3_ff;
   assign rsp_bus.duty      = duty3_ff;

   assign in_range  = (32'(m0_ff) < NUM_MOTORS);
   assign upd_state = v0_ff && rdy1 && in_range;

   assign v0_in = rdy0 ? req_bus.valid : v0_ff;
   assign v1_in = rdy1 ? (v0_ff && in_range) : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   // Error, saturating integral and difference against the live state
   always_comb begin
      e1_in      = $signed({1'b0, tgt0_ff}) - $signed({1'b0, meas0_ff});
      integ_wide = (INTEG_W+1)'(integral_ff[m0_ff]) + (INTEG_W+1)'(e1_in);
      if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
         i1_in = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         i1_in = integ_wide[INTEG_W-1:0];
      end
      d1_in = DIFF_W'(e1_in) - DIFF_W'(last_err_ff[m0_ff]);
   end

   assign gp_s   = $signed({1'b0, cfg.gain_p});
   assign gi_s   = $signed({1'b0, cfg.gain_i});
   assign gd_s   = $signed({1'b0, cfg.gain_d});
   assign pe2_in = PE_W'(gp_s) * PE_W'(e1_ff);
   assign pi2_in = PI_W'(gi_s) * PI_W'(i1_ff);
   assign pd2_in = PD_W'(gd_s) * PD_W'(d1_ff);

   // Sum, drop the fraction and clamp to 0..duty_limit
   always_comb begin
      sum     = SUM_W'(pe2_ff) + SUM_W'(pi2_ff) + SUM_W'(pd2_ff);
      shifted = SUM_W'(sum >>> FRAC_BITS);
      if (sum <= 0) begin
         duty3_in = '0;
      end else if (shifted > SUM_W'(cfg.duty_limit)) begin
         duty3_in = cfg.duty_limit;
      end else begin
         duty3_in = shifted[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k < NUM_MOTORS; k++) begin
            integral_ff[k] <= '0;
            last_err_ff[k] <= '0;
         end
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         if (upd_state) begin
            integral_ff[m0_ff] <= i1_in;
            last_err_ff[m0_ff] <= e1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         m0_ff    <= req_bus.motor_select;
         tgt0_ff  <= req_bus.speed_setpoint;
         meas0_ff <= req_bus.measured_speed;
      end
      if (rdy1) begin
         m1_ff <= m0_ff;
         e1_ff <= e1_in;
         i1_ff <= i1_in;
         d1_ff <= d1_in;
      end
      if (rdy2) begin
         m2_ff  <= m1_ff;
         pe2_ff <= pe2_in;
         pi2_ff <= pi2_in;
         pd2_ff <= pd2_in;
      end
      if (rdy3) begin
         m3_ff    <= m2_ff;
         duty3_ff <= duty3_in;
      end
   end

`ifndef SYNTHESIS
   // Duty never goes above the programmed limit
   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (duty3_ff <= cfg.duty_limit))
      else $error("duty above duty_limit");

   // A stalled input stage always holds a request
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rdy0 |-> v0_ff)
      else $error("input stalled while empty");

   // State write lands the integral that went down the pipe
   a_state_write: assert property (@(posedge clock) disable iff (reset)
      upd_state |=> (integral_ff[$past(m0_ff)] == i1_ff) && v1_ff)
      else $error("integral state does not match stage 1");
`endif

endmodule

@@ bench/dmsp_duty_checker.sv @@
`timescale 1ns / 100ps
// Duty checker: snoops CSR writes and both channels, predicts every duty response and compares.
module dmsp_duty_checker
   import dmsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dmsp_req_if                   req_mon,
   dmsp_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    checked_count,
   output int                    zero_count,
   output int                    limit_count
);

   typedef struct packed {
      logic [MOTOR_W-1:0] motor;
      logic [DUTY_W-1:0]  duty;
   } duty_result_type;

   pid_cfg_type              pid_gains;
   logic signed [INTEG_W-1:0] motor_integral [NUM_MOTORS];
   logic signed [ERR_W-1:0]   motor_last_err [NUM_MOTORS];
   duty_result_type          duty_expect_q [$];

   // Advance the per-motor integral and previous error, return the expected duty.
   function automatic duty_result_type predict_duty(input logic [MOTOR_W-1:0] m,
                                                    input logic [SPEED_W-1:0] tgt,
                                                    input logic [SPEED_W-1:0] meas);
      logic signed [ERR_W-1:0] err;
      longint integ_next;
      longint diff;
      longint pid_sum;
      longint scaled;
      duty_result_type res;
      err = $signed({1'b0, tgt}) - $signed({1'b0, meas});
      integ_next = longint'(motor_integral[m]) + longint'(err);
      if (integ_next > 64'sd2147483647)
         integ_next = 64'sd2147483647;
      else if (integ_next < -64'sd2147483648)
         integ_next = -64'sd2147483648;
      diff = longint'(err) - longint'(motor_last_err[m]);
      pid_sum = longint'(pid_gains.gain_p) * longint'(err)
              + longint'(pid_gains.gain_i) * integ_next
              + longint'(pid_gains.gain_d) * diff;
      res.motor = m;
      if (pid_sum <= 0) begin
         res.duty = '0;
         zero_count++;
      end else begin
         scaled = pid_sum >>> FRAC_BITS;
         if (scaled > longint'(pid_gains.duty_limit)) begin
            res.duty = pid_gains.duty_limit;
            limit_count++;
         end else begin
            res.duty = scaled[DUTY_W-1:0];
         end
      end
      motor_integral[m] = integ_next[INTEG_W-1:0];
      motor_last_err[m] = err;
      return res;
   endfunction

   always @(posedge clock) begin
      duty_result_type want;
      if (reset) begin
         pid_gains.gain_p     = '0;
         pid_gains.gain_i     = '0;
         pid_gains.gain_d     = '0;
         pid_gains.duty_limit = DUTY_RESET;
         for (int k = 0; k < NUM_MOTORS; k++) begin
            motor_integral[k] = '0;
            motor_last_err[k] = '0;
         end
         duty_expect_q.delete();
      end else begin
         // Pop before push so a response never matches a request of the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (duty_expect_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response: expected none, got motor %0d duty %0d",
                        $time, rsp_mon.motor_out, rsp_mon.duty);
            end else begin
               want = duty_expect_q.pop_front();
               checked_count++;
               if (rsp_mon.motor_out !== want.motor) begin
                  mismatch_count++;
                  $display("%0t: motor_out mismatch: expected %0d, got %0d", $time,
                           want.motor, rsp_mon.motor_out);
               end
               if (rsp_mon.duty !== want.duty) begin
                  mismatch_count++;
                  $display("%0t: duty mismatch on motor %0d: expected %0d, got %0d",
                           $time, want.motor, want.duty, rsp_mon.duty);
               end
            end
         end
         if (req_mon.valid && req_mon.ready && int'(req_mon.motor_select) < NUM_MOTORS)
            duty_expect_q.push_back(predict_duty(req_mon.motor_select, req_mon.speed_setpoint,
                                                 req_mon.measured_speed));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_GAIN_P:     pid_gains.gain_p     = csr_pwdata[GAIN_W-1:0];
               REG_GAIN_I:     pid_gains.gain_i     = csr_pwdata[GAIN_W-1:0];
               REG_GAIN_D:     pid_gains.gain_d     = csr_pwdata[GAIN_W-1:0];
               REG_DUTY_LIMIT: pid_gains.duty_limit = csr_pwdata[DUTY_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= duty_expect_q.size();
   end

endmodule

@@ bench/dual_motor_speed_pid_unit_test.sv @@
`timescale 1ns / 100ps
// Top of the PID unit bench: clock, reset, speed request and CSR stimulus, verdict.
module dual_motor_speed_pid_unit_test
   import dmsp_pkg::*;
();

   localparam int RANDOM_ITEMS    = 800;
   localparam int WIND_PAIRS      = 32;
   localparam int HOLD_OFF_CYCLES = 200;

   typedef enum int {
      GAINS_SMALL,
      GAINS_PROP,
      GAINS_FULL,
      GAINS_EXTREME
   } gain_mix_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int zero_count;
   int limit_count;
   int sent_count;
   int setting_count;
   bit tx_idle_en;
   bit rx_idle_en;
   bit rsp_hold_off;

   dmsp_req_if req_if();
   dmsp_rsp_if rsp_if();

   dual_motor_speed_pid_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dmsp_duty_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .zero_count     (zero_count),
      .limit_count    (limit_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #(20_000_000);
      $display("FAIL");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (rsp_hold_off && !hold_taken) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_taken = 1'b1;
         end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_speed(input logic [MOTOR_W-1:0] motor,
                             input logic [SPEED_W-1:0] tgt,
                             input logic [SPEED_W-1:0] meas);
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.motor_select   <= motor;
      req_if.speed_setpoint <= tgt;
      req_if.measured_speed <= meas;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   // Pick a measured speed that keeps target = measured + err in range.
   task automatic send_error(input logic [MOTOR_W-1:0] motor, input int err);
      int meas;
      if (err >= 0)
         meas = $urandom_range(0, 65535 - err);
      else
         meas = $urandom_range(-err, 65535);
      send_speed(motor, SPEED_W'(meas + err), SPEED_W'(meas));
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Junk in the upper data bits must be dropped by the unit.
   task automatic configure(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                            input logic [GAIN_W-1:0] gd, input logic [DUTY_W-1:0] limit);
      csr_write(REG_GAIN_P, {16'($urandom), gp});
      csr_write(REG_GAIN_I, {16'($urandom), gi});
      csr_write(REG_GAIN_D, {16'($urandom), gd});
      csr_write(REG_DUTY_LIMIT, {22'($urandom), limit});
      setting_count++;
   endtask

   initial begin
      int phase_len;
      int span;
      int phase_idx;
      int sent_random;
      gain_mix_type mix;
      logic [GAIN_W-1:0] gp;
      logic [GAIN_W-1:0] gi;
      logic [GAIN_W-1:0] gd;
      logic [DUTY_W-1:0] limit;

      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.motor_select   <= '0;
      req_if.speed_setpoint <= '0;
      req_if.measured_speed <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      sent_count    = 0;
      setting_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset gains are zero: every duty is zero.
      send_speed(1'b0, 16'd0, 16'd0);
      send_speed(1'b1, 16'hFFFF, 16'd0);
      send_speed(1'b0, 16'd0, 16'hFFFF);
      drain();

      // Unity proportional gain: in range, negative, zero and clamped sums.
      configure(16'd256, 16'd0, 16'd0, 10'd1023);
      send_speed(1'b0, 16'd100, 16'd0);
      send_speed(1'b1, 16'd0, 16'd5);
      send_speed(1'b0, 16'd1023, 16'd0);
      send_speed(1'b1, 16'd40000, 16'd100);
      send_speed(1'b0, 16'd7, 16'd7);
      drain();

      // Integral and derivative terms, with a change of error sign.
      configure(16'd0, 16'd1, 16'd256, 10'd500);
      send_speed(1'b1, 16'd300, 16'd0);
      send_speed(1'b1, 16'd300, 16'd0);
      send_speed(1'b1, 16'd0, 16'd300);
      send_speed(1'b0, 16'hFFFF, 16'd0);
      drain();

      // Largest gains against a zero limit, then the largest limit.
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
      send_speed(1'b0, 16'hFFFF, 16'd0);
      send_speed(1'b1, 16'd0, 16'hFFFF);
      drain();
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
      send_speed(1'b0, 16'hFFFF, 16'd0);
      send_speed(1'b1, 16'd0, 16'hFFFF);
      send_speed(1'b0, 16'd32768, 16'd32767);
      drain();

      sent_random = 0;
      phase_idx = 0;
      while (sent_random < RANDOM_ITEMS) begin
         phase_len = $urandom_range(40, 120);
         mix = gain_mix_type'($urandom_range(0, 3));
         limit = DUTY_W'($urandom_range(0, 1023));
         case (mix)
            GAINS_SMALL: begin
               gp = GAIN_W'($urandom_range(0, 1023));
               gi = GAIN_W'($urandom_range(0, 15));
               gd = GAIN_W'($urandom_range(0, 1023));
            end
            GAINS_PROP: begin
               gp = GAIN_W'($urandom_range(0, 4095));
               gi = '0;
               gd = '0;
            end
            GAINS_FULL: begin
               gp = GAIN_W'($urandom);
               gi = GAIN_W'($urandom);
               gd = GAIN_W'($urandom);
            end
            default: begin
               gp = $urandom_range(0, 1) ? '1 : '0;
               gi = $urandom_range(0, 1) ? '1 : '0;
               gd = $urandom_range(0, 1) ? '1 : '0;
               limit = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
         configure(gp, gi, gd, limit);
         case ($urandom_range(0, 3))
            0: span = 64;
            1: span = 1024;
            2: span = 16384;
            default: span = 65535;
         endcase
         tx_idle_en = ($urandom_range(0, 3) != 0);
         rx_idle_en = ($urandom_range(0, 3) != 0);
         // Stall the response side long enough to back the pipe up into the request side.
         if (phase_idx == 2) begin
            tx_idle_en = 1'b0;
            rsp_hold_off = 1'b1;
         end
         for (int n = 0; n < phase_len; n++) begin
            if ($urandom_range(0, 7) == 0)
               send_speed(MOTOR_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom));
            else
               send_error(MOTOR_W'($urandom_range(0, NUM_MOTORS - 1)),
                          int'($urandom_range(0, 2 * span)) - span);
         end
         sent_random += phase_len;
         phase_idx++;
         drain();
      end

      // Wind motor 0's integral up and motor 1's down, then step back against the
      // accumulated sum with no idling on either side.
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      configure(16'd0, 16'd1, 16'd0, DUTY_W'($urandom_range(1, 1023)));
      for (int n = 0; n < WIND_PAIRS; n++) begin
         send_speed(1'b0, 16'hFFFF, 16'd0);
         send_speed(1'b1, 16'd0, 16'hFFFF);
      end
      for (int n = 0; n < 16; n++) begin
         send_speed(1'b0, 16'd0, 16'd1);
         send_speed(1'b1, 16'd1, 16'd0);
         send_speed(1'b0, 16'd0, 16'hFFFF);
         send_speed(1'b1, 16'hFFFF, 16'd0);
      end
      drain();

      $display("Sent %0d speed requests under %0d gain settings, ending with integral windup",
               sent_count, setting_count);
      $display("Checked %0d duty responses: %0d zero, %0d clamped, %0d in between",
               checked_count, zero_count, limit_count,
               checked_count - zero_count - limit_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/dmsp_pkg.sv
sv/dmsp_ifs.sv
sv/dmsp_csr.sv
sv/dual_motor_speed_pid_unit.sv
bench/dmsp_duty_checker.sv
bench/dual_motor_speed_pid_unit_test.sv
